// ===== sv/panel_gateway_priority_arbiter_defines.svh =====
// assertion helpers, clocked on clk with async active-low reset rst_n
`ifndef PANEL_GATEWAY_PRIORITY_ARBITER_DEFINES_SVH
`define PANEL_GATEWAY_PRIORITY_ARBITER_DEFINES_SVH

// same-cycle implication
`define PGPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pgpa_pkg.sv =====
package pgpa_pkg;

    localparam int CODE_W = 8;

    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [1:0] {
        KIND_ENABLE  = 2'd0,
        KIND_GATEWAY = 2'd1,
        KIND_PANEL   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  enable;
        logic  connected;
        code_t code;
    } item_t;

    typedef struct packed {
        code_t output_code;
        logic  code_changed;
        logic  pnl_start;
        logic  pnl_release;
        logic  accepted;
    } result_t;

endpackage

// ===== sv/pgpa_core.sv =====
`include "panel_gateway_priority_arbiter_defines.svh"

module pgpa_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  pgpa_pkg::code_t       cfg_wdata,
    input  logic                  step,
    input  pgpa_pkg::item_t       item,
    output pgpa_pkg::result_t     res
);

    pgpa_pkg::code_t idle_reg;
    pgpa_pkg::code_t gateway_reg;
    pgpa_pkg::code_t gateway_next;
    pgpa_pkg::code_t cur_reg;
    pgpa_pkg::code_t cur_next;
    logic            enabled_reg;
    logic            enabled_next;
    logic            active_reg;
    logic            active_next;
    logic            suppressed_reg;
    logic            suppressed_next;

    logic            press;
    logic            started;
    logic            released;
    logic            accepted;

    always_comb
    begin
        gateway_next    = gateway_reg;
        cur_next        = cur_reg;
        enabled_next    = enabled_reg;
        active_next     = active_reg;
        suppressed_next = suppressed_reg;
        started         = 1'b0;
        released        = 1'b0;
        accepted        = 1'b0;
        press           = item.connected && (item.code != idle_reg);
        unique case (item.kind)
            pgpa_pkg::KIND_ENABLE:
            begin
                released        = active_reg;
                enabled_next    = item.enable;
                active_next     = 1'b0;
                suppressed_next = 1'b1;
                cur_next        = gateway_reg;
            end
            pgpa_pkg::KIND_GATEWAY:
            begin
                if (!((item.code != idle_reg) && active_reg))
                begin
                    accepted     = 1'b1;
                    gateway_next = item.code;
                    if (active_reg)
                    begin
                        suppressed_next = 1'b1;
                    end
                    cur_next = item.code;
                end
            end
            pgpa_pkg::KIND_PANEL:
            begin
                released = !press && active_reg;
                if (!enabled_reg)
                begin
                    active_next     = 1'b0;
                    suppressed_next = 1'b1;
                    cur_next        = gateway_reg;
                end
                else if (suppressed_reg)
                begin
                    if (!press)
                    begin
                        active_next     = 1'b0;
                        suppressed_next = 1'b0;
                        cur_next        = gateway_reg;
                    end
                end
                else
                begin
                    started     = press && !active_reg;
                    active_next = press;
                    if (started)
                    begin
                        gateway_next = idle_reg;
                    end
                    if (press)
                    begin
                        cur_next = item.code;
                    end
                    else if (released)
                    begin
                        cur_next = gateway_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.output_code  = cur_next;
        res.code_changed = (cur_next != cur_reg);
        res.pnl_start    = started;
        res.pnl_release  = released;
        res.accepted     = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg       <= '0;
            gateway_reg    <= '0;
            cur_reg        <= '0;
            enabled_reg    <= 1'b0;
            active_reg     <= 1'b0;
            suppressed_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            idle_reg       <= cfg_wdata;
            gateway_reg    <= cfg_wdata;
            cur_reg        <= cfg_wdata;
            enabled_reg    <= 1'b0;
            active_reg     <= 1'b0;
            suppressed_reg <= 1'b1;
        end
        else if (step)
        begin
            gateway_reg    <= gateway_next;
            cur_reg        <= cur_next;
            enabled_reg    <= enabled_next;
            active_reg     <= active_next;
            suppressed_reg <= suppressed_next;
        end
    end

    `PGPA_ASSERT_NOW(a_start_release_excl, step, !(res.pnl_start && res.pnl_release), "panel start and release on one word")
    `PGPA_ASSERT_NOW(a_accept_gateway_only, step && res.accepted, item.kind == pgpa_pkg::KIND_GATEWAY, "accept outside gateway request")
    `PGPA_ASSERT_NEXT(a_start_takes_over, step && !cfg_wen && res.pnl_start, active_reg && (gateway_reg == idle_reg), "panel start left gateway command")
    `PGPA_ASSERT_NEXT(a_cfg_reload, cfg_wen, suppressed_reg && !active_reg && !enabled_reg && (cur_reg == idle_reg), "idle write did not reload state")

endmodule

// ===== sv/panel_gateway_priority_arbiter.sv =====
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   enable, connected, code[7:0], zero pad to 16    kind[1:0]
// m_axis    out  output_code[7:0], code_changed, pnl_start,
//                pnl_release, accepted, zero pad to 16           -
// cfg       in   cfg_wdata = idle_code[7:0], written when cfg_wen
//
// one word per clock while m_tready stays high; words pass the input, then the result register
// the input register and the result register each take a new word while the next stage drains
// rst_n is asynchronous: idle code 0, panel disabled and suppressed, both registers empty
// a stall on m_tready holds the result and backs up into the input register, then s_tready drops
// an idle code write reloads all arbitration state in the same cycle

module panel_gateway_priority_arbiter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,      // idle_code
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // enable, connected, code[7:0], pad
    input  logic [1:0]  s_tuser,        // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata         // output_code[7:0], changed, started, released, accepted, pad
);

    logic                in_valid_reg;
    logic                in_valid_next;
    pgpa_pkg::item_t     in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    pgpa_pkg::result_t   out_res_reg;
    pgpa_pkg::result_t   res;
    logic                advance;
    logic                s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    pgpa_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (in_item_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.kind      <= pgpa_pkg::kind_t'(s_tuser);
            in_item_reg.enable    <= s_tdata[0];
            in_item_reg.connected <= s_tdata[1];
            in_item_reg.code      <= s_tdata[9:2];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.accepted, out_res_reg.pnl_release,
                       out_res_reg.pnl_start, out_res_reg.code_changed,
                       out_res_reg.output_code};

endmodule

// ===== bench/panel_gateway_priority_arbiter_checker.sv =====
`timescale 1ns / 100ps

module panel_gateway_priority_arbiter_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,        // enable, connected, code[7:0], pad
    input  logic [1:0]  s_tuser,        // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,        // output_code[7:0], changed, started, released, accepted, pad
    output int          errors,
    output int          outstanding
);

    pgpa_pkg::code_t   idle_byte;
    pgpa_pkg::code_t   gw_pending;
    pgpa_pkg::code_t   driven;
    logic              pnl_en;
    logic              pnl_held;
    logic              pnl_blocked;
    pgpa_pkg::result_t predicted_out[$];

    function automatic void restore_defaults();
        gw_pending  = idle_byte;
        driven      = idle_byte;
        pnl_en      = 1'b0;
        pnl_held    = 1'b0;
        pnl_blocked = 1'b1;
    endfunction

    function automatic pgpa_pkg::result_t arbitrate_word(pgpa_pkg::item_t w);
        pgpa_pkg::result_t r;
        pgpa_pkg::code_t   prior;
        logic              held_next;
        prior = driven;
        r = '0;
        case (w.kind)
            pgpa_pkg::KIND_ENABLE:
            begin
                r.pnl_release = pnl_held;
                pnl_en      = w.enable;
                pnl_held    = 1'b0;
                pnl_blocked = 1'b1;
                driven      = gw_pending;
            end
            pgpa_pkg::KIND_GATEWAY:
            begin
                if (!(w.code != idle_byte && pnl_held))
                begin
                    r.accepted = 1'b1;
                    gw_pending = w.code;
                    if (pnl_held)
                        pnl_blocked = 1'b1;
                    driven = w.code;
                end
            end
            pgpa_pkg::KIND_PANEL:
            begin
                held_next = w.connected && (w.code != idle_byte);
                r.pnl_start   = held_next && !pnl_held;
                r.pnl_release = !held_next && pnl_held;
                if (!pnl_en)
                begin
                    r.pnl_start = 1'b0;
                    pnl_held    = 1'b0;
                    pnl_blocked = 1'b1;
                    driven      = gw_pending;
                end
                else if (pnl_blocked)
                begin
                    r.pnl_start = 1'b0;
                    if (!held_next)
                    begin
                        pnl_held    = 1'b0;
                        pnl_blocked = 1'b0;
                        driven      = gw_pending;
                    end
                end
                else
                begin
                    if (r.pnl_start)
                        gw_pending = idle_byte;
                    pnl_held = held_next;
                    if (held_next)
                        driven = w.code;
                    else if (r.pnl_release)
                        driven = gw_pending;
                end
            end
            default:
            begin
            end
        endcase
        r.output_code  = driven;
        r.code_changed = (driven != prior);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pgpa_pkg::item_t   in_word;
        pgpa_pkg::result_t got;
        pgpa_pkg::result_t want;
        if (!rst_n)
        begin
            idle_byte = '0;
            restore_defaults();
            predicted_out.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                idle_byte = cfg_wdata;
                restore_defaults();
            end
            if (s_tvalid && s_tready)
            begin
                in_word.kind      = pgpa_pkg::kind_t'(s_tuser);
                in_word.enable    = s_tdata[0];
                in_word.connected = s_tdata[1];
                in_word.code      = s_tdata[9:2];
                predicted_out.push_back(arbitrate_word(in_word));
            end
            if (m_tvalid && m_tready)
            begin
                got.output_code  = m_tdata[7:0];
                got.code_changed = m_tdata[8];
                got.pnl_start    = m_tdata[9];
                got.pnl_release  = m_tdata[10];
                got.accepted     = m_tdata[11];
                if (predicted_out.size() == 0)
                begin
                    $error("result word %0h with nothing expected", m_tdata);
                    errors++;
                end
                else
                begin
                    want = predicted_out.pop_front();
                    check_field("output_code", want.output_code, got.output_code);
                    check_field("code_changed", 8'(want.code_changed), 8'(got.code_changed));
                    check_field("pnl_start", 8'(want.pnl_start), 8'(got.pnl_start));
                    check_field("pnl_release", 8'(want.pnl_release), 8'(got.pnl_release));
                    check_field("accepted", 8'(want.accepted), 8'(got.accepted));
                end
            end
            outstanding <= predicted_out.size();
        end
    end

endmodule

// ===== bench/panel_gateway_priority_arbiter_tb.sv =====
`timescale 1ns / 100ps

module panel_gateway_priority_arbiter_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         PHASES      = 6;
    localparam int         PHASE_WORDS = 255;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wen;
    logic [7:0]      cfg_wdata;
    logic            s_tvalid;
    logic            s_tready;
    logic [15:0]     s_tdata;
    logic [1:0]      s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [15:0]     m_tdata;
    int              errors;
    int              outstanding;

    int              src_idle_pct = 10;
    int              dst_idle_pct = 60;
    logic            hold_req     = 1'b0;
    pgpa_pkg::code_t idle_now;

    panel_gateway_priority_arbiter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    panel_gateway_priority_arbiter_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver, with one long hold-off to back the block up
    initial
    begin : receiver
        logic hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    task automatic send_word(input logic [1:0] kind, input logic en, input logic conn,
                             input pgpa_pkg::code_t code);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, code, conn, en};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_word();
        int              sel;
        logic [1:0]      kind;
        pgpa_pkg::code_t code;
        sel  = $urandom_range(99);
        kind = (sel < 8) ? pgpa_pkg::KIND_ENABLE : (sel < 38) ? pgpa_pkg::KIND_GATEWAY :
               (sel < 96) ? pgpa_pkg::KIND_PANEL : KIND_UNUSED;
        code = ($urandom_range(99) < 30) ? idle_now : pgpa_pkg::code_t'($urandom_range(255));
        send_word(kind, $urandom_range(9) != 0, $urandom_range(9) != 0, code);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_idle(input pgpa_pkg::code_t value);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        idle_now   = value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin : stimulus
        pgpa_pkg::code_t phase_idle [PHASES];
        phase_idle = '{8'hff, 8'h00, 8'h80, 8'h01, 8'h00, 8'h7f};
        phase_idle[2] = pgpa_pkg::code_t'($urandom_range(255));
        phase_idle[4] = pgpa_pkg::code_t'($urandom_range(255));
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        idle_now  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_idle(8'h3c);
        send_word(KIND_UNUSED,            1'b1, 1'b1, 8'hff);
        send_word(pgpa_pkg::KIND_GATEWAY, 1'b0, 1'b0, 8'hff);
        send_word(pgpa_pkg::KIND_GATEWAY, 1'b1, 1'b1, 8'h00);
        send_word(pgpa_pkg::KIND_PANEL,   1'b1, 1'b1, 8'ha5);   // panel disabled
        send_word(pgpa_pkg::KIND_ENABLE,  1'b1, 1'b0, 8'h00);
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b1, 8'h11);   // still suppressed
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b0, 8'h11);   // disconnected lifts suppression
        send_word(pgpa_pkg::KIND_GATEWAY, 1'b0, 1'b0, 8'h42);
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b1, 8'hff);   // panel takes over
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b1, 8'h00);
        send_word(pgpa_pkg::KIND_GATEWAY, 1'b0, 1'b0, 8'h77);   // refused
        send_word(pgpa_pkg::KIND_GATEWAY, 1'b0, 1'b0, 8'h3c);   // stop while held
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b1, 8'h00);
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b1, 8'h3c);   // idle lifts suppression
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b1, 8'h80);
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b0, 8'h80);   // release
        send_word(pgpa_pkg::KIND_PANEL,   1'b0, 1'b1, 8'h01);
        send_word(pgpa_pkg::KIND_ENABLE,  1'b0, 1'b1, 8'hff);   // disable drops active press
        send_word(pgpa_pkg::KIND_PANEL,   1'b1, 1'b1, 8'hfe);
        send_word(pgpa_pkg::KIND_ENABLE,  1'b1, 1'b1, 8'hff);
        send_word(pgpa_pkg::KIND_PANEL,   1'b1, 1'b1, 8'h3c);
        send_word(pgpa_pkg::KIND_PANEL,   1'b1, 1'b1, 8'h55);
        send_word(pgpa_pkg::KIND_ENABLE,  1'b1, 1'b0, 8'h00);   // re-enable ends active press
        send_word(pgpa_pkg::KIND_GATEWAY, 1'b1, 1'b1, 8'h00);
        send_word(KIND_UNUSED,            1'b0, 1'b0, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            write_idle(phase_idle[p]);
            src_idle_pct = (p < 2) ? 10 : (p < 4) ? 60 : 0;
            dst_idle_pct = (p < 2) ? 60 : (p < 4) ? 10 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 0 && n == 40)
                    hold_req = 1'b1;
                send_random_word();
            end
        end
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pgpa_pkg.sv
sv/pgpa_core.sv
sv/panel_gateway_priority_arbiter.sv
bench/panel_gateway_priority_arbiter_checker.sv
bench/panel_gateway_priority_arbiter_tb.sv
